FILE: rtl/core/scnh_pkg.sv
// Package for the segment/circle nearest-hit unit.
// Holds the field widths, command codes, the control state type and the slot tag.
// No dependencies.
`default_nettype none

package scnh_pkg;

    localparam int ID_BITS       = 16;
    localparam int RADIUS_BITS   = 12;
    localparam int SLOT_BITS     = 5;
    // Tag slot field is wide enough for the largest table the unit supports.
    localparam int TAG_SLOT_BITS = 6;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_DEN,
        S_SCAN,
        S_DRAIN,
        S_SUM
    } t_state;

    // Travels with each table read down the compute pipeline.
    typedef struct packed {
        logic                     vld;
        logic                     skip;
        logic [TAG_SLOT_BITS-1:0] slot;
    } t_tag;

endpackage

`default_nettype wire

FILE: rtl/core/scnh_if.sv
// Handshake interfaces for the command channel and the result channel.
// Depends on scnh_pkg for field widths.
`default_nettype none

interface scnh_in_if #(
    parameter int COORD_BITS = 16
);
    logic                                  valid;
    logic                                  ready;
    logic                                  command;
    logic [scnh_pkg::SLOT_BITS-1:0]        slot;
    logic [scnh_pkg::ID_BITS-1:0]          entity_id;
    logic signed [COORD_BITS-1:0]          circle_x;
    logic signed [COORD_BITS-1:0]          circle_y;
    logic [scnh_pkg::RADIUS_BITS-1:0]      circle_radius;
    logic signed [COORD_BITS-1:0]          from_x;
    logic signed [COORD_BITS-1:0]          from_y;
    logic signed [COORD_BITS-1:0]          to_x;
    logic signed [COORD_BITS-1:0]          to_y;
    logic signed [COORD_BITS-1:0]          origin_x;
    logic signed [COORD_BITS-1:0]          origin_y;

    modport source (
        output valid, command, slot, entity_id, circle_x, circle_y, circle_radius,
               from_x, from_y, to_x, to_y, origin_x, origin_y,
        input  ready
    );
    modport sink (
        input  valid, command, slot, entity_id, circle_x, circle_y, circle_radius,
               from_x, from_y, to_x, to_y, origin_x, origin_y,
        output ready
    );
endinterface

interface scnh_out_if;
    logic                           valid;
    logic                           ready;
    logic                           is_summary;
    logic                           found;
    logic [scnh_pkg::SLOT_BITS-1:0] hit_slot;
    logic [scnh_pkg::ID_BITS-1:0]   hit_id;
    logic                           last;

    modport source (
        output valid, is_summary, found, hit_slot, hit_id, last,
        input  ready
    );
    modport sink (
        input  valid, is_summary, found, hit_slot, hit_id, last,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/scnh_table.sv
// Circle table: one synchronous memory with a registered read port and per-entry valid bits.
// Depends on scnh_pkg.
`default_nettype none

module scnh_table #(
    parameter int NUM_SLOTS  = 32,
    parameter int COORD_BITS = 16,
    parameter int AW         = $clog2(NUM_SLOTS)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr_en,
    input  wire logic [scnh_pkg::SLOT_BITS-1:0]   i_wr_slot,
    input  wire logic [scnh_pkg::ID_BITS-1:0]     i_wr_id,
    input  wire logic signed [COORD_BITS-1:0]     i_wr_x,
    input  wire logic signed [COORD_BITS-1:0]     i_wr_y,
    input  wire logic [scnh_pkg::RADIUS_BITS-1:0] i_wr_r,
    input  wire logic                             i_rd_en,
    input  wire logic [AW-1:0]                    i_rd_addr,
    input  wire scnh_pkg::t_tag                   i_rd_tag,
    output scnh_pkg::t_tag                        o_rd_tag,
    output logic [scnh_pkg::ID_BITS-1:0]          o_id,
    output logic signed [COORD_BITS-1:0]          o_x,
    output logic signed [COORD_BITS-1:0]          o_y,
    output logic [scnh_pkg::RADIUS_BITS-1:0]      o_r
);
    import scnh_pkg::*;

    localparam int WW = ID_BITS + 2 * COORD_BITS + RADIUS_BITS;

    logic [WW-1:0]        r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;
    logic [WW-1:0]        r_rd_data;
    logic                 r_rd_vld;
    t_tag                 r_tag;
    logic [TAG_SLOT_BITS-1:0] wr_slot_ext;
    logic                 wr_ok;
    logic [AW-1:0]        wr_addr;

    // Writes beyond the table depth are dropped.
    assign wr_slot_ext = TAG_SLOT_BITS'(i_wr_slot);
    assign wr_ok       = wr_slot_ext < TAG_SLOT_BITS'(NUM_SLOTS);
    assign wr_addr     = wr_slot_ext[AW-1:0];

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_ok) begin
            r_mem[wr_addr] <= {i_wr_id, i_wr_x, i_wr_y, i_wr_r};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Valid bits and the read tag are control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            r_tag    <= '0;
        end else begin
            if (i_wr_en && wr_ok) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
                r_tag    <= i_rd_tag;
            end
        end
    end

    // An entry never written reads as empty.
    assign o_rd_tag = r_tag;
    assign o_id     = r_rd_data[WW-1 -: ID_BITS];
    assign o_x      = r_rd_data[2*COORD_BITS+RADIUS_BITS-1 -: COORD_BITS];
    assign o_y      = r_rd_data[COORD_BITS+RADIUS_BITS-1 -: COORD_BITS];
    assign o_r      = r_rd_vld ? r_rd_data[RADIUS_BITS-1:0] : '0;

endmodule

`default_nettype wire

FILE: rtl/core/scnh_geom.sv
// Pipelined segment/circle distance test, one table entry per cycle while i_en is high.
// Depends on scnh_pkg; fed by scnh_table.
`default_nettype none

module scnh_geom #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire scnh_pkg::t_tag                   i_tag,
    input  wire logic [scnh_pkg::ID_BITS-1:0]     i_id,
    input  wire logic signed [COORD_BITS-1:0]     i_x,
    input  wire logic signed [COORD_BITS-1:0]     i_y,
    input  wire logic [scnh_pkg::RADIUS_BITS-1:0] i_r,
    input  wire logic [scnh_pkg::ID_BITS-1:0]     i_shooter,
    input  wire logic signed [COORD_BITS-1:0]     i_fx,
    input  wire logic signed [COORD_BITS-1:0]     i_fy,
    input  wire logic signed [COORD_BITS-1:0]     i_tx,
    input  wire logic signed [COORD_BITS-1:0]     i_ty,
    input  wire logic signed [COORD_BITS-1:0]     i_ox,
    input  wire logic signed [COORD_BITS-1:0]     i_oy,
    input  wire logic signed [COORD_BITS:0]       i_dx,
    input  wire logic signed [COORD_BITS:0]       i_dy,
    input  wire logic [2*COORD_BITS+1:0]          i_den,
    output scnh_pkg::t_tag                        o_tag,
    output logic                                  o_hit,
    output logic [scnh_pkg::ID_BITS-1:0]          o_id,
    output logic [2*COORD_BITS+1:0]               o_dorg,
    output logic                                  o_busy
);
    import scnh_pkg::*;

    localparam int P  = COORD_BITS + 1;
    localparam int RB = 2 * RADIUS_BITS;
    localparam int WA = 4 * P + 1;
    localparam int WB = 2 * P + RB + 1;
    localparam int W  = ((WA > WB) ? WA : WB) + 1;

    // Stage A: differences.
    t_tag                   r_tag_a;
    logic [ID_BITS-1:0]     r_a_id;
    logic [RADIUS_BITS-1:0] r_a_r;
    logic signed [P-1:0]    r_a_wx, r_a_wy, r_a_ex, r_a_ey, r_a_gx, r_a_gy;
    logic signed [P-1:0]    n_a_wx, n_a_wy, n_a_ex, n_a_ey, n_a_gx, n_a_gy;
    t_tag                   n_tag_a;
    // Stage B: products.
    t_tag                   r_tag_b;
    logic [ID_BITS-1:0]     r_b_id;
    logic [RB-1:0]          r_b_r2;
    logic signed [2*P-1:0]  r_b_tw1, r_b_tw2, r_b_cr1, r_b_cr2;
    logic signed [2*P-1:0]  r_b_fxx, r_b_fyy, r_b_txx, r_b_tyy, r_b_oxx, r_b_oyy;
    // Stage C: sums.
    t_tag                   r_tag_c;
    logic [ID_BITS-1:0]     r_c_id;
    logic [RB-1:0]          r_c_r2;
    logic signed [2*P:0]    r_c_t;
    logic [2*P-1:0]         r_c_cm, r_c_dfrom, r_c_dto, r_c_dorg;
    logic signed [2*P:0]    n_c_t, n_c_cross;
    logic [2*P-1:0]         n_c_cm;
    // Stage D: case flags and split products.
    t_tag                   r_tag_d;
    logic [ID_BITS-1:0]     r_d_id;
    logic [2*P-1:0]         r_d_dorg;
    logic                   r_d_near_from, r_d_near_to, r_d_in_from, r_d_in_to;
    logic [2*P-1:0]         r_d_aa, r_d_ab, r_d_bb;
    logic [RB+P-1:0]        r_d_rh, r_d_rl;
    logic [P-1:0]           c_hi, c_lo, den_hi, den_lo;
    // Stage E: wide sums.
    t_tag                   r_tag_e;
    logic [ID_BITS-1:0]     r_e_id;
    logic [2*P-1:0]         r_e_dorg;
    logic                   r_e_near_from, r_e_near_to, r_e_in_from, r_e_in_to;
    logic [W-1:0]           r_e_c2, r_e_rd;

    // Stage A inputs.
    assign n_a_wx = i_x - i_fx;
    assign n_a_wy = i_y - i_fy;
    assign n_a_ex = i_x - i_tx;
    assign n_a_ey = i_y - i_ty;
    assign n_a_gx = i_x - i_ox;
    assign n_a_gy = i_y - i_oy;

    // Empty entries and the shooter's own circle never hit.
    always_comb begin
        n_tag_a      = i_tag;
        n_tag_a.skip = (i_r == '0) || (i_id == i_shooter);
    end

    // Stage C inputs.
    assign n_c_t     = r_b_tw1 + r_b_tw2;
    assign n_c_cross = r_b_cr1 - r_b_cr2;
    assign n_c_cm    = n_c_cross[2*P] ? (2*P)'(-n_c_cross) : n_c_cross[2*P-1:0];

    // Stage D splits.
    assign c_hi   = r_c_cm[2*P-1:P];
    assign c_lo   = r_c_cm[P-1:0];
    assign den_hi = i_den[2*P-1:P];
    assign den_lo = i_den[P-1:0];

    // Tag pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
            r_tag_c <= '0;
            r_tag_d <= '0;
            r_tag_e <= '0;
        end else if (i_en) begin
            r_tag_a <= n_tag_a;
            r_tag_b <= r_tag_a;
            r_tag_c <= r_tag_b;
            r_tag_d <= r_tag_c;
            r_tag_e <= r_tag_d;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Stage A.
            r_a_id <= i_id;
            r_a_r  <= i_r;
            r_a_wx <= n_a_wx;
            r_a_wy <= n_a_wy;
            r_a_ex <= n_a_ex;
            r_a_ey <= n_a_ey;
            r_a_gx <= n_a_gx;
            r_a_gy <= n_a_gy;
            // Stage B.
            r_b_id  <= r_a_id;
            r_b_r2  <= RB'(r_a_r) * RB'(r_a_r);
            r_b_tw1 <= r_a_wx * i_dx;
            r_b_tw2 <= r_a_wy * i_dy;
            r_b_cr1 <= r_a_wx * i_dy;
            r_b_cr2 <= r_a_wy * i_dx;
            r_b_fxx <= r_a_wx * r_a_wx;
            r_b_fyy <= r_a_wy * r_a_wy;
            r_b_txx <= r_a_ex * r_a_ex;
            r_b_tyy <= r_a_ey * r_a_ey;
            r_b_oxx <= r_a_gx * r_a_gx;
            r_b_oyy <= r_a_gy * r_a_gy;
            // Stage C.
            r_c_id    <= r_b_id;
            r_c_r2    <= r_b_r2;
            r_c_t     <= n_c_t;
            r_c_cm    <= n_c_cm;
            r_c_dfrom <= $unsigned(r_b_fxx) + $unsigned(r_b_fyy);
            r_c_dto   <= $unsigned(r_b_txx) + $unsigned(r_b_tyy);
            r_c_dorg  <= $unsigned(r_b_oxx) + $unsigned(r_b_oyy);
            // Stage D.
            r_d_id        <= r_c_id;
            r_d_dorg      <= r_c_dorg;
            r_d_near_from <= (i_den == '0) || (r_c_t <= 0);
            r_d_near_to   <= r_c_t >= $signed({1'b0, i_den});
            r_d_in_from   <= r_c_dfrom < (2*P+RB)'(r_c_r2);
            r_d_in_to     <= r_c_dto < (2*P+RB)'(r_c_r2);
            r_d_aa        <= (2*P)'(c_hi) * (2*P)'(c_hi);
            r_d_ab        <= (2*P)'(c_hi) * (2*P)'(c_lo);
            r_d_bb        <= (2*P)'(c_lo) * (2*P)'(c_lo);
            r_d_rh        <= (RB+P)'(r_c_r2) * (RB+P)'(den_hi);
            r_d_rl        <= (RB+P)'(r_c_r2) * (RB+P)'(den_lo);
            // Stage E.
            r_e_id        <= r_d_id;
            r_e_dorg      <= r_d_dorg;
            r_e_near_from <= r_d_near_from;
            r_e_near_to   <= r_d_near_to;
            r_e_in_from   <= r_d_in_from;
            r_e_in_to     <= r_d_in_to;
            r_e_c2        <= (W'(r_d_aa) << (2*P)) + (W'(r_d_ab) << (P+1)) + W'(r_d_bb);
            r_e_rd        <= (W'(r_d_rh) << P) + W'(r_d_rl);
        end
    end

    // Final decision: nearest point is an endpoint or the interior of the segment.
    always_comb begin
        if (r_e_near_from) begin
            o_hit = !r_tag_e.skip && r_e_in_from;
        end else if (r_e_near_to) begin
            o_hit = !r_tag_e.skip && r_e_in_to;
        end else begin
            o_hit = !r_tag_e.skip && (r_e_c2 < r_e_rd);
        end
    end

    assign o_tag  = r_tag_e;
    assign o_id   = r_e_id;
    assign o_dorg = r_e_dorg;
    assign o_busy = i_tag.vld || r_tag_a.vld || r_tag_b.vld || r_tag_c.vld
                 || r_tag_d.vld || r_tag_e.vld;

endmodule

`default_nettype wire

FILE: rtl/core/segment_circle_nearest_hit_unit.sv
// Top level of the segment/circle nearest-hit unit: control, query registers,
// nearest tracking and the result register. Depends on scnh_pkg, scnh_if,
// scnh_table and scnh_geom.
//
//   port    | dir | item
//   --------+-----+----------------------------------------------------
//   i_cmd   | in  | table write (command 0) or segment query (command 1)
//   o_res   | out | one item per hit, then one summary item with last=1
//
// A query passes two setup states (S_SQ, S_DEN), makes one table read per
// slot, drains the six-stage read and compute pipeline and ends with the
// summary state. The single read port of the circle table sets the scan rate.
// i_cmd is ready only between queries. A stalled result freezes the whole
// scan pipeline. Reset is synchronous and marks every table entry empty; no
// clearing pass is needed.
`default_nettype none

module segment_circle_nearest_hit_unit #(
    parameter int NUM_SLOTS  = 32,
    parameter int COORD_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    scnh_in_if.sink    i_cmd,
    scnh_out_if.source o_res
);
    import scnh_pkg::*;

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int P  = COORD_BITS + 1;

    t_state r_state, n_state;

    logic in_acc, wr_en, issue, en, load_sum, take_hit;
    logic [AW-1:0] r_addr;

    // Query registers.
    logic [ID_BITS-1:0]          r_shooter;
    logic signed [COORD_BITS-1:0] r_fx, r_fy, r_tx, r_ty, r_ox, r_oy;
    logic signed [P-1:0]         r_dx, r_dy;
    logic signed [2*P-1:0]       r_sxx, r_syy;
    logic [2*P-1:0]              r_den;

    // Nearest tracking.
    logic                        r_found;
    logic [2*P-1:0]              r_best_d;
    logic [SLOT_BITS-1:0]        r_best_slot;
    logic [ID_BITS-1:0]          r_best_id;

    // Result register.
    logic                        r_out_vld;
    logic                        r_out_sum, r_out_found, r_out_last;
    logic [SLOT_BITS-1:0]        r_out_slot;
    logic [ID_BITS-1:0]          r_out_id;

    t_tag                        rd_tag, tbl_tag, f_tag;
    logic [ID_BITS-1:0]          tbl_id, f_id;
    logic signed [COORD_BITS-1:0] tbl_x, tbl_y;
    logic [RADIUS_BITS-1:0]      tbl_r;
    logic                        f_hit, busy;
    logic [2*P-1:0]              f_dorg;

    // The pipeline advances whenever the result register can take an item.
    assign en       = !r_out_vld || o_res.ready;
    assign in_acc   = i_cmd.valid && i_cmd.ready;
    assign take_hit = en && f_tag.vld && f_hit;

    // Next state and control.
    always_comb begin
        n_state     = r_state;
        i_cmd.ready = 1'b0;
        wr_en       = 1'b0;
        issue       = 1'b0;
        load_sum    = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                wr_en       = i_cmd.valid && (i_cmd.command == CMD_WRITE);
                if (i_cmd.valid && (i_cmd.command == CMD_QUERY)) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_state = S_DEN;
            end
            S_DEN: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                issue = en;
                if (en && (r_addr == AW'(NUM_SLOTS - 1))) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (en && !busy) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                load_sum = en;
                if (en) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (in_acc) begin
            r_addr <= '0;
        end else if (issue) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    // Query capture and the segment length, squared in S_SQ and summed in S_DEN.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_cmd.command == CMD_QUERY)) begin
            r_shooter <= i_cmd.entity_id;
            r_fx      <= i_cmd.from_x;
            r_fy      <= i_cmd.from_y;
            r_tx      <= i_cmd.to_x;
            r_ty      <= i_cmd.to_y;
            r_ox      <= i_cmd.origin_x;
            r_oy      <= i_cmd.origin_y;
            r_dx      <= i_cmd.to_x - i_cmd.from_x;
            r_dy      <= i_cmd.to_y - i_cmd.from_y;
        end
        if (r_state == S_SQ) begin
            r_sxx <= r_dx * r_dx;
            r_syy <= r_dy * r_dy;
        end
        if (r_state == S_DEN) begin
            r_den <= $unsigned(r_sxx) + $unsigned(r_syy);
        end
    end

    always_comb begin
        rd_tag      = '0;
        rd_tag.vld  = issue;
        rd_tag.slot = TAG_SLOT_BITS'(r_addr);
    end

    scnh_table #(
        .NUM_SLOTS  (NUM_SLOTS),
        .COORD_BITS (COORD_BITS),
        .AW         (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_slot (i_cmd.slot),
        .i_wr_id   (i_cmd.entity_id),
        .i_wr_x    (i_cmd.circle_x),
        .i_wr_y    (i_cmd.circle_y),
        .i_wr_r    (i_cmd.circle_radius),
        .i_rd_en   (en),
        .i_rd_addr (r_addr),
        .i_rd_tag  (rd_tag),
        .o_rd_tag  (tbl_tag),
        .o_id      (tbl_id),
        .o_x       (tbl_x),
        .o_y       (tbl_y),
        .o_r       (tbl_r)
    );

    scnh_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_tag     (tbl_tag),
        .i_id      (tbl_id),
        .i_x       (tbl_x),
        .i_y       (tbl_y),
        .i_r       (tbl_r),
        .i_shooter (r_shooter),
        .i_fx      (r_fx),
        .i_fy      (r_fy),
        .i_tx      (r_tx),
        .i_ty      (r_ty),
        .i_ox      (r_ox),
        .i_oy      (r_oy),
        .i_dx      (r_dx),
        .i_dy      (r_dy),
        .i_den     (r_den),
        .o_tag     (f_tag),
        .o_hit     (f_hit),
        .o_id      (f_id),
        .o_dorg    (f_dorg),
        .o_busy    (busy)
    );

    // Nearest hit so far; the earlier slot wins on equal distance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (in_acc && (i_cmd.command == CMD_QUERY)) begin
            r_found <= 1'b0;
        end else if (take_hit) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_hit && (!r_found || (f_dorg < r_best_d))) begin
            r_best_d    <= f_dorg;
            r_best_slot <= f_tag.slot[SLOT_BITS-1:0];
            r_best_id   <= f_id;
        end
    end

    // Result register: per-hit items, then the summary.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= take_hit || load_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_hit) begin
            r_out_sum   <= 1'b0;
            r_out_found <= 1'b1;
            r_out_slot  <= f_tag.slot[SLOT_BITS-1:0];
            r_out_id    <= f_id;
            r_out_last  <= 1'b0;
        end else if (load_sum) begin
            r_out_sum   <= 1'b1;
            r_out_found <= r_found;
            r_out_slot  <= r_found ? r_best_slot : '0;
            r_out_id    <= r_found ? r_best_id : '0;
            r_out_last  <= 1'b1;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.is_summary = r_out_sum;
    assign o_res.found      = r_out_found;
    assign o_res.hit_slot   = r_out_slot;
    assign o_res.hit_id     = r_out_id;
    assign o_res.last       = r_out_last;

    // The pipeline is empty whenever a new command can be taken.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !busy)
        else $error("scan pipeline busy while idle");

    // Leaving the summary state always presents the closing item.
    a_sum_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SUM) && en) |=> (o_res.valid && o_res.last && o_res.is_summary))
        else $error("summary item missing");

    // Scan results only appear while a query is running.
    a_hit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_tag.vld |-> ((r_state == S_SCAN) || (r_state == S_DRAIN)))
        else $error("scan result outside a query");

    // The nearest record is only cleared by a new query.
    a_found_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_found) |-> $past(in_acc && (i_cmd.command == CMD_QUERY)))
        else $error("nearest record lost mid query");

endmodule

`default_nettype wire
